[rtl/core/assert_macros.svh]
// ------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the selection engine checkers.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define PSEL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psel assertion failed");

// antecedent holds in this cycle, consequent in the next cycle
`define PSEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psel assertion failed");

`endif

[rtl/core/psel_pkg.sv]
// ------------------------------------------------------------------------
// psel_pkg
// Types, constants and helpers of the population selection engine.
// ------------------------------------------------------------------------
package psel_pkg;

    localparam int POP_MAX        = 1024;
    localparam int MAX_TOURNAMENT = 64;
    localparam int POP_W          = 10;
    localparam int SIZE_W         = 11;
    localparam int FIT_W          = 32;
    localparam int K_W            = 7;
    localparam int PROB_W         = 16;
    localparam int SUM_W          = FIT_W + POP_W;
    localparam int TGT_W          = SUM_W + PROB_W;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION  = 3'd0,
        CFG_METHOD     = 3'd1,
        CFG_TOUR_SIZE  = 3'd2,
        CFG_WIN_PROB   = 3'd3,
        CFG_POP_SIZE   = 3'd4,
        CFG_RNG_SEED   = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        METH_TOURNAMENT = 2'd0,
        METH_BINARY     = 2'd1,
        METH_UNIFORM    = 2'd2,
        METH_ROULETTE   = 2'd3
    } method_t;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SELECT = 1'b1
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAW,
        ST_MODW,
        ST_EVAL,
        ST_COIN,
        ST_SUM,
        ST_RDRAW,
        ST_MUL,
        ST_SCAN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [31:0]       dividend;
        logic [SIZE_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [POP_W-1:0] rem;
    } mod_rsp_t;

    function automatic logic better(input logic dir, input logic [FIT_W-1:0] a,
                                    input logic [FIT_W-1:0] b);
        logic signed [FIT_W-1:0] sa;
        logic signed [FIT_W-1:0] sb;
        sa = a;
        sb = b;
        return dir ? (sa > sb) : (sa < sb);
    endfunction

endpackage

[rtl/core/psel_if.sv]
// ------------------------------------------------------------------------
// psel_in_if / psel_out_if
// Valid/ready channels carrying command beats and result beats.
// ------------------------------------------------------------------------
interface psel_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [psel_pkg::POP_W-1:0]    slot_index;
    logic signed [psel_pkg::FIT_W-1:0] fitness_value;

    modport source (output valid, output opcode, output slot_index,
                    output fitness_value, input ready);
    modport sink   (input valid, input opcode, input slot_index,
                    input fitness_value, output ready);
endinterface

interface psel_out_if;
    logic                       valid;
    logic                       ready;
    logic [psel_pkg::POP_W-1:0] selected_index;
    logic                       error;

    modport source (output valid, output selected_index, output error, input ready);
    modport sink   (input valid, input selected_index, input error, output ready);
endinterface

[rtl/core/population_selection_engine.sv]
// ------------------------------------------------------------------------
// population_selection_engine
// Fitness table in a simple dual-port synchronous RAM with tournament, binary
// tournament, uniform and roulette selection driven by an internal LFSR.
//
//   channel   dir   beat
//   in_ch     sink  opcode, slot_index, fitness_value
//   out_ch    src   selected_index, error
//   cfg_*     in    cfg_we, cfg_index, cfg_data
//
// Each index draw runs through the bit-serial remainder unit and then one
// RAM read; a k-tournament makes k draws and a binary tournament makes two
// draws and a coin toss. Roulette sums the RAM in one sweep and then scans
// it again up to the target. Reset clears control state only; the table
// is undefined until written. Writes keep flowing while a result beat
// waits on out_ch.ready.
// ------------------------------------------------------------------------
module population_selection_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    psel_in_if.sink                             in_ch,
    psel_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [psel_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psel_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import psel_pkg::*;

    logic              dir_reg;
    logic [1:0]        method_reg;
    logic [K_W-1:0]    k_reg;
    logic [PROB_W-1:0] wp_reg;
    logic [SIZE_W-1:0] pop_reg;

    state_t            state_reg;
    state_t            state_next;
    logic [K_W-1:0]    cnt_reg;
    logic [K_W-1:0]    cnt_next;
    logic [POP_W-1:0]  best_idx_reg;
    logic [POP_W-1:0]  best_idx_next;
    logic [FIT_W-1:0]  best_fit_reg;
    logic [FIT_W-1:0]  best_fit_next;
    logic [POP_W-1:0]  cand_reg;
    logic [POP_W-1:0]  cand_next;
    logic [SIZE_W-1:0] addr_reg;
    logic [SIZE_W-1:0] addr_next;
    logic              dv_reg;
    logic              dv_next;
    logic [POP_W-1:0]  didx_reg;
    logic [POP_W-1:0]  didx_next;
    logic [SUM_W-1:0]  total_reg;
    logic [SUM_W-1:0]  total_next;
    logic [SUM_W-1:0]  run_reg;
    logic [SUM_W-1:0]  run_next;
    logic [TGT_W-1:0]  target_reg;
    logic [TGT_W-1:0]  target_next;
    logic [PROB_W-1:0] r_reg;
    logic [PROB_W-1:0] r_next;
    logic [POP_W-1:0]  res_idx_reg;
    logic [POP_W-1:0]  res_idx_next;
    logic              res_err_reg;
    logic              res_err_next;
    logic              out_vld_reg;
    logic              out_vld_next;
    logic [POP_W-1:0]  out_idx_reg;
    logic [POP_W-1:0]  out_idx_next;
    logic              out_err_reg;
    logic              out_err_next;

    logic [FIT_W-1:0]  fit_mem [POP_MAX];
    logic [FIT_W-1:0]  rd_data;
    logic              mem_we;
    logic [POP_W-1:0]  mem_ra;

    logic              lfsr_step;
    logic              seed_we;
    logic [31:0]       lfsr_next;
    mod_req_t          mod_req;
    mod_rsp_t          mod_rsp;

    logic              in_acc;
    logic              issue;
    logic [SUM_W-1:0]  pos_fit;
    logic              bad_cfg;

    psel_lfsr u_lfsr (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (lfsr_step),
        .seed_we    (seed_we),
        .seed       (cfg_data),
        .next_state (lfsr_next)
    );

    psel_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    assign seed_we = cfg_we && (cfg_index == CFG_RNG_SEED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg    <= 1'b1;
            method_reg <= METH_TOURNAMENT;
            k_reg      <= K_W'(2);
            wp_reg     <= PROB_W'(52429);
            pop_reg    <= SIZE_W'(POP_MAX);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIRECTION: dir_reg    <= cfg_data[0];
                CFG_METHOD:    method_reg <= cfg_data[1:0];
                CFG_TOUR_SIZE: k_reg      <= cfg_data[K_W-1:0];
                CFG_WIN_PROB:  wp_reg     <= cfg_data[PROB_W-1:0];
                CFG_POP_SIZE:  pop_reg    <= cfg_data[SIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fit_mem[in_ch.slot_index] <= in_ch.fitness_value;
        end
        rd_data <= fit_mem[mem_ra];
    end

    assign in_ch.ready    = (state_reg == ST_IDLE);
    assign in_acc         = in_ch.valid && in_ch.ready;
    assign out_ch.valid   = out_vld_reg;
    assign out_ch.selected_index = out_idx_reg;
    assign out_ch.error   = out_err_reg;

    assign issue   = (addr_reg < pop_reg);
    assign pos_fit = rd_data[FIT_W-1] ? '0 : SUM_W'(rd_data);

    always_comb
    begin
        bad_cfg = (pop_reg == '0) || (pop_reg > SIZE_W'(POP_MAX));
        unique case (method_reg)
            METH_TOURNAMENT: bad_cfg = bad_cfg || (k_reg < K_W'(2))
                                     || (k_reg > K_W'(MAX_TOURNAMENT));
            METH_BINARY:     bad_cfg = bad_cfg || (wp_reg == '0);
            METH_ROULETTE:   bad_cfg = bad_cfg || !dir_reg;
            default:         ;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        best_idx_next  = best_idx_reg;
        best_fit_next  = best_fit_reg;
        cand_next      = cand_reg;
        addr_next      = addr_reg;
        dv_next        = 1'b0;
        didx_next      = didx_reg;
        total_next     = total_reg;
        run_next       = run_reg;
        target_next    = target_reg;
        r_next         = r_reg;
        res_idx_next   = res_idx_reg;
        res_err_next   = res_err_reg;
        out_vld_next   = out_vld_reg && !out_ch.ready;
        out_idx_next   = out_idx_reg;
        out_err_next   = out_err_reg;
        mem_we         = 1'b0;
        mem_ra         = addr_reg[POP_W-1:0];
        lfsr_step      = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = lfsr_next;
        mod_req.divisor  = pop_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.opcode == OP_WRITE)
                    begin
                        mem_we = 1'b1;
                    end
                    else if (bad_cfg)
                    begin
                        res_idx_next = '0;
                        res_err_next = 1'b1;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        res_err_next = 1'b0;
                        cnt_next     = '0;
                        addr_next    = '0;
                        total_next   = '0;
                        state_next   = (method_reg == METH_ROULETTE) ? ST_SUM : ST_DRAW;
                    end
                end
            end
            ST_DRAW:
            begin
                lfsr_step     = 1'b1;
                mod_req.start = 1'b1;
                state_next    = ST_MODW;
            end
            ST_MODW:
            begin
                mem_ra = mod_rsp.rem;
                if (mod_rsp.done)
                begin
                    cand_next  = mod_rsp.rem;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                unique case (method_reg)
                    METH_TOURNAMENT:
                    begin
                        if ((cnt_reg == '0) || better(dir_reg, rd_data, best_fit_reg))
                        begin
                            best_idx_next = cand_reg;
                            best_fit_next = rd_data;
                        end
                        cnt_next     = cnt_reg + K_W'(1);
                        res_idx_next = best_idx_next;
                        state_next   = (cnt_next == k_reg) ? ST_OUT : ST_DRAW;
                    end
                    METH_BINARY:
                    begin
                        if (cnt_reg == '0)
                        begin
                            best_idx_next = cand_reg;
                            best_fit_next = rd_data;
                            cnt_next      = K_W'(1);
                            state_next    = ST_DRAW;
                        end
                        else
                        begin
                            if (!better(dir_reg, best_fit_reg, rd_data))
                            begin
                                best_idx_next = cand_reg;
                                cand_next     = best_idx_reg;
                            end
                            state_next = ST_COIN;
                        end
                    end
                    default:
                    begin
                        res_idx_next = cand_reg;
                        state_next   = ST_OUT;
                    end
                endcase
            end
            ST_COIN:
            begin
                lfsr_step    = 1'b1;
                res_idx_next = (lfsr_next[31:16] < wp_reg) ? best_idx_reg : cand_reg;
                state_next   = ST_OUT;
            end
            ST_SUM:
            begin
                if (issue)
                begin
                    addr_next = addr_reg + SIZE_W'(1);
                end
                dv_next   = issue;
                didx_next = addr_reg[POP_W-1:0];
                if (dv_reg)
                begin
                    total_next = total_reg + pos_fit;
                end
                if (!issue && !dv_reg)
                begin
                    state_next = ST_RDRAW;
                end
            end
            ST_RDRAW:
            begin
                lfsr_step = 1'b1;
                r_next    = lfsr_next[31:16];
                if (total_reg == '0)
                begin
                    res_idx_next = '0;
                    res_err_next = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                target_next = TGT_W'(total_reg) * TGT_W'(r_reg);
                addr_next   = '0;
                run_next    = '0;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    addr_next = addr_reg + SIZE_W'(1);
                end
                dv_next   = issue;
                didx_next = addr_reg[POP_W-1:0];
                if (dv_reg)
                begin
                    run_next = run_reg + pos_fit;
                    if (target_reg < {run_next, {PROB_W{1'b0}}})
                    begin
                        res_idx_next = didx_reg;
                        state_next   = ST_OUT;
                    end
                end
                else if (!issue)
                begin
                    res_idx_next = POP_W'(pop_reg - SIZE_W'(1));
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_vld_reg || out_ch.ready)
                begin
                    out_vld_next = 1'b1;
                    out_idx_next = res_idx_reg;
                    out_err_next = res_err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
            dv_reg      <= 1'b0;
            cnt_reg     <= '0;
            addr_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            dv_reg      <= dv_next;
            cnt_reg     <= cnt_next;
            addr_reg    <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_fit_reg <= best_fit_next;
        cand_reg     <= cand_next;
        didx_reg     <= didx_next;
        total_reg    <= total_next;
        run_reg      <= run_next;
        target_reg   <= target_next;
        r_reg        <= r_next;
        res_idx_reg  <= res_idx_next;
        res_err_reg  <= res_err_next;
        out_idx_reg  <= out_idx_next;
        out_err_reg  <= out_err_next;
    end

endmodule

[rtl/core/psel_lfsr.sv]
// ------------------------------------------------------------------------
// psel_lfsr
// 32-bit Galois LFSR, right shifting, loadable from the seed register.
// ------------------------------------------------------------------------
module psel_lfsr (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        seed_we,
    input  logic [31:0] seed,
    output logic [31:0] next_state
);
    import psel_pkg::*;

    logic [31:0] state_reg;

    assign next_state = state_reg[0] ? ((state_reg >> 1) ^ LFSR_MASK) : (state_reg >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= 32'd1;
        end
        else if (seed_we)
        begin
            state_reg <= (seed == 32'd0) ? 32'd1 : seed;
        end
        else if (step)
        begin
            state_reg <= next_state;
        end
    end

endmodule

[rtl/core/psel_mod.sv]
// ------------------------------------------------------------------------
// psel_mod
// Bit-serial restoring remainder: 32-bit draw modulo population size.
// ------------------------------------------------------------------------
module psel_mod (
    input  logic                clk,
    input  logic                rst_n,
    input  psel_pkg::mod_req_t  req,
    output psel_pkg::mod_rsp_t  rsp
);
    import psel_pkg::*;

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [4:0]       cnt_reg;
    logic [4:0]       cnt_next;
    logic [31:0]      dvd_reg;
    logic [31:0]      dvd_next;
    logic [SIZE_W-1:0] div_reg;
    logic [SIZE_W-1:0] div_next;
    logic [POP_W-1:0] rem_reg;
    logic [POP_W-1:0] rem_next;
    logic [POP_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[31]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            dvd_next  = req.dividend;
            div_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= div_reg)
            begin
                rem_next = POP_W'(trial - div_reg);
            end
            else
            begin
                rem_next = trial[POP_W-1:0];
            end
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

[rtl/core/psel_checker.sv]
// ------------------------------------------------------------------------
// psel_checker
// Port-level checks of the selection engine, bound to the top level.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module psel_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_opcode,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [psel_pkg::POP_W-1:0] out_index,
    input logic                       out_error
);
    import psel_pkg::*;

    `PSEL_ASSERT_SAME(a_err_index_zero, clk, rst_n, out_valid && out_error, out_index == '0)
    `PSEL_ASSERT_NEXT(a_write_no_result, clk, rst_n,
        in_valid && in_ready && (in_opcode == OP_WRITE) && !out_valid, !out_valid)
    `PSEL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `PSEL_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
        $stable(out_index) && $stable(out_error))

endmodule

bind population_selection_engine psel_checker u_psel_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_opcode (in_ch.opcode),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_index (out_ch.selected_index),
    .out_error (out_ch.error)
);
